>>> src/gif_literal_lzw_code_packer_macros.svh
// Assertion macros for the GIF literal LZW code packer checker.
`ifndef GIF_LITERAL_LZW_CODE_PACKER_MACROS_SVH
`define GIF_LITERAL_LZW_CODE_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GIFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GIFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gifp_pkg.sv
// Shared widths, constants and helpers for the GIF literal LZW code packer.
package gifp_pkg;

    localparam int PIX_W    = 8;
    localparam int SIZE_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int CODE_W   = 9;
    localparam int CNT_W    = 9;
    localparam int OBUF_W   = 40;
    localparam int POS_W    = 6;
    localparam int REM_W    = 3;
    localparam int NUM_W    = 3;

    localparam logic [SIZE_W-1:0] MIN_SIZE   = 4'd2;
    localparam logic [SIZE_W-1:0] MAX_SIZE   = 4'd8;
    localparam logic [SIZE_W-1:0] RESET_SIZE = 4'd8;
    localparam logic [CNT_W-1:0]  RESET_CNT  = 9'd258;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [CODE_W-1:0] t_code;

    // Clamp the raw register to the usable code size range.
    function automatic t_size eff_size(input t_size raw);
        t_size s;
        s = raw;
        if (raw < MIN_SIZE) begin
            s = MIN_SIZE;
        end else if (raw > MAX_SIZE) begin
            s = MAX_SIZE;
        end
        return s;
    endfunction

endpackage

>>> src/gifp_if.sv
// Valid/ready channel interfaces: pixel input, code byte output, configuration.
interface gifp_pix_if;
    logic                             valid;
    logic                             ready;
    logic [gifp_pkg::PIX_W-1:0]       pixel_index;
    logic                             last_pixel;

    modport source (output valid, output pixel_index, output last_pixel, input ready);
    modport sink   (input valid, input pixel_index, input last_pixel, output ready);
endinterface

interface gifp_byte_if;
    logic                             valid;
    logic                             ready;
    logic [gifp_pkg::BYTE_W-1:0]      code_byte;
    logic                             last_byte;

    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

interface gifp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gifp_pkg::SIZE_W-1:0]      code_size;

    modport source (output valid, output code_size, input ready);
    modport sink   (input valid, input code_size, output ready);
endinterface

>>> src/gif_literal_lzw_code_packer.sv
// GIF literal LZW code packer: pixel indices in, LSB-first packed code bytes out.
// A pixel beat is packed in its acceptance cycle; its first byte, if any, is valid in the next cycle.
// Bytes leave one per cycle while o_byte.ready is high; a pixel produces 0 to 5 bytes, and
// the single byte output port limits the pixel rate.
// The next pixel is taken in the same cycle the previous pixel's last byte is taken.
// Synchronous active-low reset: empty output buffer, empty bit store, code size 8, no image open.
module gif_literal_lzw_code_packer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gifp_cfg_if.sink     i_cfg,
    gifp_pix_if.sink     i_pix,
    gifp_byte_if.source  o_byte
);

    logic [gifp_pkg::SIZE_W-1:0]    r_size;
    logic [6:0]                     r_acc;
    logic [gifp_pkg::REM_W-1:0]     r_held;
    logic [gifp_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_started;
    logic [gifp_pkg::OBUF_W-1:0]    r_obuf;
    logic [gifp_pkg::NUM_W-1:0]     r_onum;
    logic                           r_olast;

    logic [6:0]                     n_acc;
    logic [gifp_pkg::REM_W-1:0]     n_held;
    logic [gifp_pkg::CNT_W-1:0]     n_cnt;

    gifp_pkg::t_size                s_eff;
    logic [gifp_pkg::SIZE_W-1:0]    code_w;
    gifp_pkg::t_code                clr_code;
    gifp_pkg::t_code                eoi_code;
    gifp_pkg::t_code                pix_code;
    gifp_pkg::t_code                code_a;
    gifp_pkg::t_code                code_b;
    logic [gifp_pkg::CNT_W:0]       thr_m1;
    logic                           two_codes;
    logic                           use_b;
    logic                           use_c;
    logic [gifp_pkg::POS_W-1:0]     pos0;
    logic [gifp_pkg::POS_W-1:0]     pos1;
    logic [gifp_pkg::POS_W-1:0]     pos2;
    logic [gifp_pkg::POS_W-1:0]     total;
    logic [gifp_pkg::OBUF_W-1:0]    word;
    logic [gifp_pkg::NUM_W-1:0]     nfull;
    logic [gifp_pkg::NUM_W-1:0]     nout;
    logic [gifp_pkg::OBUF_W-1:0]    rest;

    logic                           in_fire;
    logic                           out_fire;

    assign i_cfg.ready = 1'b1;

    assign o_byte.valid     = (r_onum != '0);
    assign o_byte.code_byte = r_obuf[gifp_pkg::BYTE_W-1:0];
    assign o_byte.last_byte = r_olast && (r_onum == 3'd1);

    assign out_fire    = o_byte.valid && o_byte.ready;
    assign i_pix.ready = (r_onum == '0) || ((r_onum == 3'd1) && o_byte.ready);
    assign in_fire     = i_pix.valid && i_pix.ready;

    always_comb begin
        s_eff      = gifp_pkg::eff_size(r_size);
        code_w     = s_eff + 4'd1;
        clr_code   = gifp_pkg::t_code'(1) << s_eff;
        eoi_code   = clr_code + 9'd1;
        pix_code   = {1'b0, i_pix.pixel_index} & (clr_code - 9'd1);
        thr_m1     = (10'(1) << code_w) - 10'd1;
        two_codes  = !r_started || ({1'b0, r_cnt} >= thr_m1);

        // Code order: [clear,] literal [, end]
        code_a = two_codes ? clr_code : pix_code;
        code_b = two_codes ? pix_code : eoi_code;
        use_b  = two_codes || i_pix.last_pixel;
        use_c  = two_codes && i_pix.last_pixel;

        pos0 = gifp_pkg::POS_W'(r_held);
        pos1 = pos0 + gifp_pkg::POS_W'(code_w);
        pos2 = pos1 + gifp_pkg::POS_W'(code_w);
        if (use_c) begin
            total = pos2 + gifp_pkg::POS_W'(code_w);
        end else if (use_b) begin
            total = pos2;
        end else begin
            total = pos1;
        end

        word = gifp_pkg::OBUF_W'(r_acc)
             | (gifp_pkg::OBUF_W'(code_a) << pos0);
        if (use_b) begin
            word = word | (gifp_pkg::OBUF_W'(code_b) << pos1);
        end
        if (use_c) begin
            word = word | (gifp_pkg::OBUF_W'(eoi_code) << pos2);
        end

        nfull = total[gifp_pkg::POS_W-1:3];
        rest  = word >> {nfull, 3'b000};

        if (i_pix.last_pixel) begin
            nout   = nfull + gifp_pkg::NUM_W'(total[2:0] != 3'd0);
            n_acc  = '0;
            n_held = '0;
            n_cnt  = eoi_code + 9'd1;
        end else begin
            nout   = nfull;
            n_acc  = rest[6:0];
            n_held = total[2:0];
            n_cnt  = two_codes ? (eoi_code + 9'd1) : (r_cnt + 9'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= gifp_pkg::RESET_SIZE;
            r_acc     <= '0;
            r_held    <= '0;
            r_cnt     <= gifp_pkg::RESET_CNT;
            r_started <= 1'b0;
            r_onum    <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_size <= i_cfg.code_size;
            end
            if (in_fire) begin
                r_acc     <= n_acc;
                r_held    <= n_held;
                r_cnt     <= n_cnt;
                r_started <= !i_pix.last_pixel;
                r_onum    <= nout;
            end else if (out_fire) begin
                r_onum <= r_onum - 3'd1;
            end
        end
    end

    // Byte buffer payload; a new beat overrides the final byte leaving this cycle.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_obuf  <= word;
            r_olast <= i_pix.last_pixel;
        end else if (out_fire) begin
            r_obuf  <= r_obuf >> gifp_pkg::BYTE_W;
        end
    end

endmodule

>>> src/gifp_checker.sv
// Port-level checker for the GIF literal LZW code packer, with its bind.
`include "gif_literal_lzw_code_packer_macros.svh"

module gifp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    `GIFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output beat dropped while stalled")
    `GIFP_ASSERT_NEXT(a_last_makes_bytes, i_clk, i_rst_n, in_fire && i_in_last, i_out_valid, "last pixel produced no byte")
    `GIFP_ASSERT_NOW(a_ready_only_draining, i_clk, i_rst_n, i_in_ready && i_out_valid, i_out_ready, "pixel taken while bytes still stalled")
    `GIFP_ASSERT_NEXT(a_empty_after_last, i_clk, i_rst_n, out_fire && i_out_last && !in_fire, !i_out_valid, "bytes after final byte without new pixel")

endmodule

bind gif_literal_lzw_code_packer gifp_checker u_gifp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_last   (i_pix.last_pixel),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_last  (o_byte.last_byte)
);
